/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/core/deq_pkg.sv */
// Package with the types and constants of the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row; at most one bit is set.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_cmd_t;

endpackage

/* rtl/core/deq_if.sv */
// Valid/ready channel interfaces for the queue's operation and result items.
`timescale 1ns / 1ps

interface deq_op_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::KIND_W-1:0]    kind;
  logic signed [deq_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::WORD_W-1:0] popped_value;
  logic [deq_pkg::STATUS_W-1:0]      status;
  logic [deq_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

/* rtl/core/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps
// Usage:
//   op_i  : operation items (kind, push_value). kind selects push front,
//           push back, pop front, pop back or clear; other codes do nothing.
//   res_o : one result item per operation (popped_value, status, entry_count).
//   Words sit in a row of 16 cells, front word in cell 0. A push at the front
//   or a pop at the front shifts the whole row by one cell;
//   a push at the back fills the first empty cell, a pop at the back empties
//   the last full one. Every cell decides from its own state and its neighbors.
//   Result: registered; it appears in the cycle after the operation is accepted.
//   Throughput: one operation per cycle while res_o.ready stays high, set by
//   the registered row update and the one-deep result register.
//   Stall: while a result waits and res_o.ready is low, op_i.ready drops;
//   op_i is taken again in the cycle the waiting result is taken.
//   Reset: empties the queue and drops any pending result. Cell words are
//   not cleared; only occupied cells are ever read.
//   Errors: pop on empty returns status empty, push on full returns status
//   full; the queue is left unchanged in both cases.

`include "assert_macros.svh"

module double_ended_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_op_if.sink     op_i,
  deq_res_if.source  res_o
);

  logic                         op_accept;
  logic                         queue_full;
  logic                         queue_empty;
  deq_pkg::cell_cmd_t           cell_cmd;
  logic [deq_pkg::WORD_W-1:0]   front_word;
  logic [deq_pkg::WORD_W-1:0]   back_word;
  logic [deq_pkg::CAPACITY-1:0] valid_vec;

  logic                         res_valid_q;
  logic [deq_pkg::CNT_W-1:0]    count_q, count_d;
  logic [deq_pkg::WORD_W-1:0]   popped_q, popped_d;
  deq_pkg::status_e             status_q, status_d;

  // Accept a new operation whenever the result slot is free or being drained.
  assign op_i.ready = !res_valid_q || res_o.ready;
  assign op_accept  = op_i.valid && op_i.ready;

  assign queue_full  = (count_q == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
  assign queue_empty = (count_q == '0);

  // Decode the operation into a row command, the new count and the result.
  always_comb begin
    cell_cmd = '0;
    count_d  = count_q;
    popped_d = '0;
    status_d = deq_pkg::STATUS_OK;
    case (op_i.kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (queue_full) begin
          status_d = deq_pkg::STATUS_FULL;
        end else begin
          cell_cmd.push_front = op_accept;
          count_d             = count_q + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (queue_full) begin
          status_d = deq_pkg::STATUS_FULL;
        end else begin
          cell_cmd.push_back = op_accept;
          count_d            = count_q + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (queue_empty) begin
          status_d = deq_pkg::STATUS_EMPTY;
        end else begin
          cell_cmd.pop_front = op_accept;
          count_d            = count_q - deq_pkg::CNT_W'(1);
          popped_d           = front_word;
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (queue_empty) begin
          status_d = deq_pkg::STATUS_EMPTY;
        end else begin
          cell_cmd.pop_back = op_accept;
          count_d           = count_q - deq_pkg::CNT_W'(1);
          popped_d          = back_word;
        end
      end
      deq_pkg::KIND_CLEAR: begin
        cell_cmd.clear = op_accept;
        count_d        = '0;
      end
      default: begin
        // unused codes: report ok, change nothing
      end
    endcase
  end

  deq_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cell_cmd),
    .push_word_i  (op_i.push_value),
    .front_word_o (front_word),
    .back_word_o  (back_word),
    .valid_vec_o  (valid_vec)
  );

  // Control state: result valid flag and the entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (op_accept) begin
        res_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load with every accepted operation, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (op_accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.popped_value = popped_q;
  assign res_o.status       = status_q;
  assign res_o.entry_count  = count_q;

  // Count never runs past the capacity.
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > deq_pkg::CNT_W'(deq_pkg::CAPACITY))
  // The row holds exactly as many occupied cells as the count says.
  `ASSERT_PROP(a_count_matches_row, clk_i, rst_ni,
               $countones(valid_vec) == 32'(count_q))
  // Occupied cells always form a prefix of the row.
  `ASSERT_NEVER(a_row_prefix, clk_i, rst_ni, ((valid_vec + deq_pkg::CAPACITY'(1)) & valid_vec) != '0)
  // A push on a full queue reports full and leaves the count alone.
  `ASSERT_PROP(a_push_full, clk_i, rst_ni,
               (op_accept && queue_full &&
                (op_i.kind == deq_pkg::KIND_PUSH_FRONT ||
                 op_i.kind == deq_pkg::KIND_PUSH_BACK))
               |=> (status_q == deq_pkg::STATUS_FULL && $stable(count_q)))

endmodule

/* rtl/core/deq_cell.sv */
// One storage cell of the queue row: holds a word and its valid flag.
`timescale 1ns / 1ps

module deq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  deq_pkg::cell_cmd_t        cmd_i,
  input  logic [deq_pkg::WORD_W-1:0] push_word_i,
  input  logic [deq_pkg::WORD_W-1:0] left_data_i,
  input  logic                      left_valid_i,
  input  logic [deq_pkg::WORD_W-1:0] right_data_i,
  input  logic                      right_valid_i,
  output logic [deq_pkg::WORD_W-1:0] data_o,
  output logic                      valid_o
);

  logic [deq_pkg::WORD_W-1:0] data_q, data_d;
  logic                       valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (cmd_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.push_back) begin
      // first empty cell takes the word
      if (!valid_q && left_valid_i) begin
        data_d  = push_word_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.pop_back) begin
      // last occupied cell drops out
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

/* rtl/core/deq_chain.sv */
// Row of queue cells with the front word and the back word picked out.
`timescale 1ns / 1ps

module deq_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  deq_pkg::cell_cmd_t          cmd_i,
  input  logic [deq_pkg::WORD_W-1:0]  push_word_i,
  output logic [deq_pkg::WORD_W-1:0]  front_word_o,
  output logic [deq_pkg::WORD_W-1:0]  back_word_o,
  output logic [deq_pkg::CAPACITY-1:0] valid_vec_o
);

  logic [deq_pkg::WORD_W-1:0]   cell_data [deq_pkg::CAPACITY];
  logic [deq_pkg::CAPACITY-1:0] cell_valid;
  logic [deq_pkg::CAPACITY-1:0] right_valid;
  logic [deq_pkg::CAPACITY-1:0] is_last;

  for (genvar i = 0; i < deq_pkg::CAPACITY; i++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_data;
    logic                       left_valid;
    logic [deq_pkg::WORD_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data  = push_word_i;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == deq_pkg::CAPACITY - 1) begin : g_tail
      assign right_data     = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner
      assign right_data     = cell_data[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    assign is_last[i] = cell_valid[i] && !right_valid[i];

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .push_word_i   (push_word_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid[i]),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i])
    );
  end

  // At most one cell is last, so an AND-OR picks its word.
  always_comb begin
    back_word_o = '0;
    for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
      back_word_o = back_word_o | (cell_data[i] & {deq_pkg::WORD_W{is_last[i]}});
    end
  end

  assign front_word_o = cell_data[0];
  assign valid_vec_o  = cell_valid;

endmodule
